// ----- src/source_identifier_table_defines.svh -----
// assertion macros used by the source identifier table control
`ifndef SOURCE_IDENTIFIER_TABLE_DEFINES_SVH
`define SOURCE_IDENTIFIER_TABLE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define SIT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define SIT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/sit_pkg.sv -----
// constants and types of the source identifier table
package sit_pkg;

  localparam int STATIONS = 16;
  localparam int GW = (STATIONS > 1) ? $clog2(STATIONS) : 1;
  localparam int RAM_DEPTH = 1 << (2 * GW);
  localparam int ADDR_W = 32;
  localparam int ID_W = 16;
  localparam int ENTRY_W = ADDR_W + ID_W;

  localparam logic [1:0] STATUS_FOUND = 2'd0;
  localparam logic [1:0] STATUS_NEW = 2'd1;
  localparam logic [1:0] STATUS_BAD_GROUP = 2'd2;
  localparam logic [1:0] STATUS_FULL = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_RESULT = 3'b100
  } state_t;

  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] identifier;
    logic [1:0]      status;
  } sit_result_t;

endpackage

// ----- src/sit_ram.sv -----
// generic simple dual port ram with registered read
module sit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/sit_ctrl.sv -----
// search, append and counter control of the source identifier table
`include "source_identifier_table_defines.svh"

module sit_ctrl import sit_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                group,
  input  logic [ADDR_W-1:0]         source_address,
  output sit_result_t               res,
  input  logic                      res_take,
  output logic                      ram_wr_en,
  output logic [2*GW-1:0]           ram_wr_addr,
  output logic [ENTRY_W-1:0]        ram_wr_data,
  output logic                      ram_rd_en,
  output logic [2*GW-1:0]           ram_rd_addr,
  input  logic [ENTRY_W-1:0]        ram_rd_data
);

  state_t            state;
  state_t            state_next;
  logic [GW-1:0]     counts [STATIONS];
  logic [ID_W-1:0]   last_assigned;
  logic [GW-1:0]     k;
  logic              pend;
  logic [GW-1:0]     grp_idx;
  logic [ADDR_W-1:0] addr_q;
  logic [GW-1:0]     count_q;
  logic [ID_W-1:0]   res_id;
  logic [1:0]        res_status;

  logic              accept;
  logic              group_ok;
  logic              hit;
  logic              miss_done;
  logic              full;
  logic [ID_W-1:0]   id_new;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign group_ok  = ({1'b0, group} < 9'(STATIONS));
  assign hit       = (state == ST_SEARCH) && pend &&
                     (ram_rd_data[ENTRY_W-1:ID_W] == addr_q);
  assign miss_done = (state == ST_SEARCH) && !pend && (k == count_q);
  assign full      = (count_q == GW'(STATIONS - 1));
  assign id_new    = last_assigned + ID_W'(1);

  assign ram_rd_en   = (state == ST_SEARCH) && (k < count_q);
  assign ram_rd_addr = {grp_idx, k};
  assign ram_wr_en   = !hit && miss_done && !full;
  assign ram_wr_addr = {grp_idx, count_q};
  assign ram_wr_data = {addr_q, id_new};

  assign res.valid      = (state == ST_RESULT);
  assign res.identifier = res_id;
  assign res.status     = res_status;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = group_ok ? ST_SEARCH : ST_RESULT;
        end
      end
      ST_SEARCH: begin
        if (hit || miss_done) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      last_assigned <= '0;
      k <= '0;
      pend <= 1'b0;
      for (int i = 0; i < STATIONS; i++) begin
        counts[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (accept) begin
        k <= '0;
        pend <= 1'b0;
      end else if (state == ST_SEARCH) begin
        pend <= ram_rd_en;
        if (ram_rd_en) begin
          k <= k + GW'(1);
        end
      end
      if (ram_wr_en) begin
        counts[grp_idx] <= count_q + GW'(1);
        last_assigned <= id_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      grp_idx <= group[GW-1:0];
      addr_q  <= source_address;
      count_q <= counts[group[GW-1:0]];
      if (!group_ok) begin
        res_id     <= '0;
        res_status <= STATUS_BAD_GROUP;
      end
    end else if (hit) begin
      res_id     <= ram_rd_data[ID_W-1:0];
      res_status <= STATUS_FOUND;
    end else if (miss_done) begin
      if (full) begin
        res_id     <= '0;
        res_status <= STATUS_FULL;
      end else begin
        res_id     <= id_new;
        res_status <= STATUS_NEW;
      end
    end
  end

  `SIT_ASSERT_NOW(a_error_id_zero, res.valid && (res.status == STATUS_BAD_GROUP || res.status == STATUS_FULL), res.identifier == '0, "error word carries nonzero identifier")
  `SIT_ASSERT_NEXT(a_counter_step, ram_wr_en, last_assigned == $past(last_assigned) + ID_W'(1), "identifier counter did not advance by one")
  `SIT_ASSERT_NOW(a_scan_bound, state == ST_SEARCH, k <= count_q, "search index ran past group fill")
  `SIT_ASSERT_NEXT(a_accept_busy, accept, in_stall, "input not stalled after accepting a word")

endmodule

// ----- src/source_identifier_table.sv -----
// source identifier table: each accepted word scans up to n table entries, n the group fill
// a group number out of range skips the search; a new word is accepted only after the last result is taken
// the search reads one table entry per cycle from a single ram read port
// the output register holds a finished word while the next word is accepted
// reset clears group fill counts and the identifier counter; ram is not cleared
module source_identifier_table import sit_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        group,
  input  logic [ADDR_W-1:0] source_address,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ID_W-1:0]   identifier,
  output logic [1:0]        status
);

  sit_result_t        res;
  logic               res_take;
  logic               ram_wr_en;
  logic [2*GW-1:0]    ram_wr_addr;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic               ram_rd_en;
  logic [2*GW-1:0]    ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;

  assign res_take = res.valid && (!out_valid || !out_stall);

  sit_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .group          (group),
    .source_address (source_address),
    .res            (res),
    .res_take       (res_take),
    .ram_wr_en      (ram_wr_en),
    .ram_wr_addr    (ram_wr_addr),
    .ram_wr_data    (ram_wr_data),
    .ram_rd_en      (ram_rd_en),
    .ram_rd_addr    (ram_rd_addr),
    .ram_rd_data    (ram_rd_data)
  );

  sit_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RAM_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      identifier <= res.identifier;
      status     <= res.status;
    end
  end

endmodule

// ----- tb/sv/source_identifier_table_test.sv -----
// self-checking testbench for the source identifier table: directed and random words
module source_identifier_table_test;
  import sit_pkg::*;

  localparam int WORDS_RANDOM = 1700;
  localparam int DRAIN_AT = 850;
  localparam int HOLD_AT = 500;
  localparam int HOLD_LEN = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 30;

  typedef struct {
    logic [7:0]        group;
    logic [ADDR_W-1:0] address;
    bit                drain;
  } source_word_t;

  typedef struct packed {
    logic [ID_W-1:0] identifier;
    logic [1:0]      status;
  } id_word_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        group = '0;
  logic [ADDR_W-1:0] source_address = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ID_W-1:0]   identifier;
  logic [1:0]        status;

  source_word_t address_words[$];
  id_word_t     pending_ids[$];
  int           n_sent = 0;
  int           n_recv = 0;
  int           errors = 0;
  int           status_seen[4];
  int           gap_left;
  int           stall_left;
  int           idle_cycles;

  // predictor state
  logic [ADDR_W-1:0] known_addr[STATIONS][STATIONS-1];
  logic [ID_W-1:0]   known_id[STATIONS][STATIONS-1];
  int                fill[STATIONS];
  logic [ID_W-1:0]   id_counter;

  // generator shadow of addresses offered per group
  logic [ADDR_W-1:0] pool[STATIONS][STATIONS-1];
  int                pool_n[STATIONS];

  source_identifier_table dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .group          (group),
    .source_address (source_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .identifier     (identifier),
    .status         (status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic id_word_t assign_identifier(input logic [7:0] grp,
                                                 input logic [ADDR_W-1:0] addr);
    id_word_t res;
    int g;
    res.identifier = '0;
    res.status = STATUS_BAD_GROUP;
    if (grp >= STATIONS) return res;
    g = grp;
    for (int k = 0; k < fill[g]; k++) begin
      if (known_addr[g][k] == addr) begin
        res.identifier = known_id[g][k];
        res.status = STATUS_FOUND;
        return res;
      end
    end
    if (fill[g] >= STATIONS - 1) begin
      res.status = STATUS_FULL;
      return res;
    end
    id_counter = id_counter + 1'b1;
    known_addr[g][fill[g]] = addr;
    known_id[g][fill[g]] = id_counter;
    fill[g] = fill[g] + 1;
    res.identifier = id_counter;
    res.status = STATUS_NEW;
    return res;
  endfunction

  task automatic queue_word(input logic [7:0] grp, input logic [ADDR_W-1:0] addr);
    source_word_t w;
    bit seen;
    w.group = grp;
    w.address = addr;
    w.drain = 1'b0;
    address_words.push_back(w);
    if (grp < STATIONS) begin
      seen = 1'b0;
      for (int k = 0; k < pool_n[grp]; k++)
        if (pool[grp][k] == addr) seen = 1'b1;
      if (!seen && pool_n[grp] < STATIONS - 1) begin
        pool[grp][pool_n[grp]] = addr;
        pool_n[grp] = pool_n[grp] + 1;
      end
    end
  endtask

  task automatic queue_drain();
    source_word_t w;
    w.group = '0;
    w.address = '0;
    w.drain = 1'b1;
    address_words.push_back(w);
  endtask

  // driver
  always @(posedge clk) begin : drive
    source_word_t w;
    id_word_t want;
    bit took;
    bit quiet;
    if (rst) begin
      in_valid <= 1'b0;
      group <= '0;
      source_address <= '0;
      gap_left = 0;
      id_counter = '0;
      for (int g = 0; g < STATIONS; g++) fill[g] = 0;
    end else begin
      took = in_valid && !in_stall;
      quiet = ((n_sent / 150) % 4) == 3;
      if (took) begin
        want = assign_identifier(group, source_address);
        pending_ids.push_back(want);
        n_sent <= n_sent + 1;
        gap_left = quiet ? 0 : pick_pause();
      end
      if (in_valid && !took) begin
        // hold the stalled word
      end else if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (address_words.size() > 0 && !address_words[0].drain) begin
        w = address_words.pop_front();
        in_valid <= 1'b1;
        group <= w.group;
        source_address <= w.address;
      end else begin
        in_valid <= 1'b0;
        // sender waits until every result is back
        if (address_words.size() > 0 && !in_valid && n_sent == n_recv)
          void'(address_words.pop_front());
      end
    end
  end

  // monitor, receiver stalls and watchdog
  always @(posedge clk) begin : observe
    id_word_t want;
    bit quiet;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      idle_cycles = 0;
    end else begin
      quiet = ((n_recv / 150) % 4) == 3;
      if (out_valid && !out_stall) begin
        n_recv <= n_recv + 1;
        if (pending_ids.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, identifier %0d status %0d",
                   $time, identifier, status);
        end else begin
          want = pending_ids.pop_front();
          if (identifier !== want.identifier) begin
            errors++;
            $display("%0t: identifier mismatch, expected %0d actual %0d",
                     $time, want.identifier, identifier);
          end
          if (status !== want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, status);
          end
          status_seen[want.status]++;
        end
        if (n_recv + 1 == HOLD_AT) stall_left = HOLD_LEN;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d sent %0d received", $time, n_sent, n_recv);
        $display("[source_identifier_table] ERROR");
        $finish;
      end else begin
        if (stall_left == 0 && !quiet) stall_left = pick_pause();
        if (stall_left > 0) begin
          stall_left = stall_left - 1;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin : stimulus
    int r;
    int g;
    int bad_low;
    bad_low = (STATIONS < 256) ? STATIONS : 255;
    for (int k = 0; k < 4; k++) status_seen[k] = 0;
    for (int k = 0; k < STATIONS; k++) pool_n[k] = 0;

    // directed
    queue_word(8'(bad_low), '0);
    queue_word(8'hff, '1);
    queue_word(8'h80, 32'h5a5a_a5a5);
    queue_word(8'd0, '0);
    queue_word(8'd0, '1);
    queue_word(8'd0, '0);
    queue_word(8'd0, '1);
    for (int k = 0; k < STATIONS - 1; k++)
      queue_word(8'(STATIONS - 1), 32'h1 << k);
    queue_word(8'(STATIONS - 1), 32'hffff_0000);
    queue_word(8'(STATIONS - 1), 32'h1 << (STATIONS - 2));
    queue_drain();

    // random
    for (int n = 0; n < WORDS_RANDOM; n++) begin
      if (n == DRAIN_AT) queue_drain();
      r = $urandom_range(0, 99);
      g = $urandom_range(0, STATIONS - 1);
      if (r < 8)
        queue_word(8'($urandom_range(bad_low, 255)), $urandom);
      else if (r < 72 && pool_n[g] > 0)
        queue_word(8'(g), pool[g][$urandom_range(0, pool_n[g] - 1)]);
      else if (r < 80 && pool_n[g] > 0)
        queue_word(8'(g), pool[g][$urandom_range(0, pool_n[g] - 1)] ^
                          (32'h1 << $urandom_range(0, 31)));
      else
        queue_word(8'(g), $urandom);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (address_words.size() != 0 || in_valid || n_sent != n_recv);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (pending_ids.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, pending_ids.size());
    end
    $display("covered %0d words: %0d found, %0d new, %0d bad group, %0d group full",
             n_recv, status_seen[STATUS_FOUND], status_seen[STATUS_NEW],
             status_seen[STATUS_BAD_GROUP], status_seen[STATUS_FULL]);
    $display("with a %0d cycle receiver hold and a sender drain pause, %0d mismatches",
             HOLD_LEN, errors);
    if (errors == 0)
      $display("[source_identifier_table] OK");
    else
      $display("[source_identifier_table] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/sit_pkg.sv
src/sit_ram.sv
src/sit_ctrl.sv
src/source_identifier_table.sv
tb/sv/source_identifier_table_test.sv
